@@ sv/dwm_pkg.sv @@
// Package: request/result types, controller interface and codes for the wakeup matrix.
`timescale 1ns / 1ps
`default_nettype none
package dwm_pkg;

  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  localparam logic [1:0] KIND_READY = 2'd0;
  localparam logic [1:0] KIND_SLEEP = 2'd1;
  localparam logic [1:0] KIND_WAKE  = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  service;
    logic [15:0] dep_mask;
  } dwm_request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] target_service;
    logic [4:0] not_started;
    logic       all_started;
    logic       last;
  } dwm_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } dwm_state_t;

  typedef struct packed {
    logic latch;
    logic wait_exec;
    logic clear_exec;
    logic scan_step;
  } dwm_cmd_t;

  typedef struct packed {
    logic opcode;
    logic in_range;
    logic scan_done;
  } dwm_status_t;

endpackage
`default_nettype wire

@@ sv/dwm_ctrl.sv @@
// Controller state machine: sequences request latch, wait update, column clear and wake scan.
`timescale 1ns / 1ps
`default_nettype none
module dwm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire dwm_pkg::dwm_status_t status,
  output dwm_pkg::dwm_cmd_t         cmd,
  output logic                      busy
);
  import dwm_pkg::*;

  dwm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!status.in_range) begin
          state_next = ST_IDLE;
        end else if (status.opcode == OP_WAIT) begin
          cmd.wait_exec = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.clear_exec = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/dwm_datapath.sv @@
// Datapath: dependency rows, notify flags, release count, wake vector scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module dwm_datapath #(
  parameter int SERVICES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dwm_pkg::dwm_request_t request,
  input  wire dwm_pkg::dwm_cmd_t     cmd,
  output dwm_pkg::dwm_status_t       status,
  output dwm_pkg::dwm_result_t       result,
  output logic                       result_valid
);
  import dwm_pkg::*;

  localparam int IW = (SERVICES > 1) ? $clog2(SERVICES) : 1;
  localparam int CW = $clog2(SERVICES + 1);

  logic [SERVICES-1:0] rows [SERVICES];
  logic [SERVICES-1:0] notify;
  logic [CW-1:0]       count;
  logic [SERVICES-1:0] wake;
  logic [IW-1:0]       idx;
  dwm_request_t        req;

  logic [IW-1:0]       sidx;
  logic [SERVICES-1:0] mask_ext;
  logic [SERVICES-1:0] col;
  logic [SERVICES-1:0] wait_row;
  logic [SERVICES-1:0] wake_next;
  logic [SERVICES-1:0] idx_bit;
  logic [CW-1:0]       cnt_dec;
  logic [6:0]          cnt_cur7;
  logic [6:0]          cnt_dec7;
  logic [4:0]          show_cur;
  logic [4:0]          show_dec;

  for (genvar b = 0; b < SERVICES; b++) begin : g_mask
    if (b < 16) begin : g_in
      assign mask_ext[b] = req.dep_mask[b];
    end else begin : g_zero
      assign mask_ext[b] = 1'b0;
    end
  end

  always_comb begin
    sidx      = IW'(req.service);
    col       = {{(SERVICES-1){1'b0}}, 1'b1} << sidx;
    idx_bit   = {{(SERVICES-1){1'b0}}, 1'b1} << idx;
    wait_row  = rows[sidx] & mask_ext;
    for (int i = 0; i < SERVICES; i++) begin
      wake_next[i] = notify[i] && ((rows[i] & ~col) == '0);
    end
    cnt_dec   = (count != '0) ? count - CW'(1) : count;
    cnt_cur7  = 7'(count);
    cnt_dec7  = 7'(cnt_dec);
    show_cur  = (cnt_cur7 > 7'd31) ? 5'd31 : cnt_cur7[4:0];
    show_dec  = (cnt_dec7 > 7'd31) ? 5'd31 : cnt_dec7[4:0];
    status.opcode    = req.opcode;
    status.in_range  = (6'(req.service) < 6'(SERVICES));
    status.scan_done = (idx == IW'(SERVICES - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SERVICES; i++) begin
        rows[i] <= '1;
      end
      notify       <= '0;
      count        <= CW'(SERVICES);
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.wait_exec) begin
        rows[sidx]   <= wait_row;
        result_valid <= 1'b1;
        if (wait_row == '0) begin
          notify[sidx] <= 1'b0;
          count        <= cnt_dec;
        end else begin
          notify[sidx] <= 1'b1;
        end
      end
      if (cmd.clear_exec) begin
        for (int i = 0; i < SERVICES; i++) begin
          rows[i] <= rows[i] & ~col;
        end
      end
      if (cmd.scan_step && wake[idx]) begin
        notify[idx]  <= 1'b0;
        count        <= cnt_dec;
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
    end
    if (cmd.wait_exec) begin
      result.target_service <= req.service;
      result.last           <= 1'b1;
      if (wait_row == '0) begin
        result.kind        <= KIND_READY;
        result.not_started <= show_dec;
        result.all_started <= (cnt_dec == '0);
      end else begin
        result.kind        <= KIND_SLEEP;
        result.not_started <= show_cur;
        result.all_started <= (count == '0);
      end
    end
    if (cmd.clear_exec) begin
      wake <= wake_next;
      idx  <= '0;
    end
    if (cmd.scan_step) begin
      idx <= idx + IW'(1);
      if (wake[idx]) begin
        wake[idx]             <= 1'b0;
        result.kind           <= KIND_WAKE;
        result.target_service <= 4'(idx);
        result.not_started    <= show_dec;
        result.all_started    <= (cnt_dec == '0);
        result.last           <= ((wake & ~idx_bit) == '0);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/dependency_wakeup_matrix_core.sv @@
// Top level: dependency wakeup matrix, controller plus datapath.
// Wait request: busy while in the EXEC state after acceptance; its single result strobes for one
//   cycle, registered at the end of EXEC. A new request is accepted only once busy falls.
// Signal request: busy through the column clear (EXEC) and the one-row-per-cycle scan (SCAN);
//   each wake strobes in the cycle after its scan step, at most one per cycle, the last
//   one no later than the cycle in which busy falls.
// The receiver cannot stall; results are shown once. Synchronous reset sets every row
//   to all ones, clears all notify flags and loads the not-started count with SERVICES.
`timescale 1ns / 1ps
`default_nettype none
module dependency_wakeup_matrix_core #(
  parameter int SERVICES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire dwm_pkg::dwm_request_t request,
  output logic                       result_valid,
  output dwm_pkg::dwm_result_t       result
);
  import dwm_pkg::*;

  dwm_cmd_t    cmd;
  dwm_status_t status;

  dwm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dwm_datapath #(
    .SERVICES (SERVICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for the dependency wakeup matrix: directed rows, random request rounds, result predictor.
`timescale 1ns / 1ps
module tb_top;
  import dwm_pkg::*;

  localparam int NSVC = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 234;

  typedef struct {
    dwm_request_t req;
    bit           typed;
    dwm_result_t  res;
  } directed_row_t;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  dwm_request_t request;
  logic         result_valid;
  dwm_result_t  result;

  dependency_wakeup_matrix_core #(.SERVICES(NSVC)) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result)
  );

  // predicted matrix state
  logic [15:0] dep_rows [NSVC];
  logic        notify   [NSVC];
  int          unreleased;

  dwm_result_t result_q [$];
  int          errors;
  int          sent;
  int          cycle_count;
  logic [15:0] signaled;
  bit          row_typed;
  dwm_result_t row_expect;
  int          perm [NSVC];
  directed_row_t directed_rows [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic dwm_request_t mk_req(input logic op, input int svc, input logic [15:0] mask);
    dwm_request_t r;
    r.opcode   = op;
    r.service  = svc[3:0];
    r.dep_mask = mask;
    return r;
  endfunction

  function automatic dwm_result_t mk_res(input logic [1:0] kind, input int svc, input int ns);
    dwm_result_t r;
    r.kind           = kind;
    r.target_service = svc[3:0];
    r.not_started    = ns[4:0];
    r.all_started    = (ns == 0);
    r.last           = 1'b1;
    return r;
  endfunction

  function automatic string fmt_result(input dwm_result_t r);
    return $sformatf("kind=%0d svc=%0d not_started=%0d all=%0b last=%0b",
                     r.kind, r.target_service, r.not_started, r.all_started, r.last);
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void note_outcome(input logic [1:0] kind, input int svc, input bit keep);
    dwm_result_t r;
    if (unreleased > 0 && kind != KIND_SLEEP) unreleased--;
    r = mk_res(kind, svc, unreleased);
    r.last = 1'b0;
    if (keep) result_q.push_back(r);
  endfunction

  function automatic void compute_outcomes(input dwm_request_t req, input bit keep);
    int s;
    int n;
    s = req.service;
    n = 0;
    if (req.opcode == OP_WAIT) begin
      dep_rows[s] &= req.dep_mask;
      if (dep_rows[s] == 16'h0000) begin
        notify[s] = 1'b0;
        note_outcome(KIND_READY, s, keep);
      end else begin
        notify[s] = 1'b1;
        note_outcome(KIND_SLEEP, s, keep);
      end
      n = 1;
    end else begin
      for (int i = 0; i < NSVC; i++) begin
        dep_rows[i][s] = 1'b0;
        if (notify[i] && dep_rows[i] == 16'h0000) begin
          notify[i] = 1'b0;
          note_outcome(KIND_WAKE, i, keep);
          n++;
        end
      end
    end
    if (keep && n > 0) result_q[$].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    dwm_result_t exp_r;
    if (!rst) begin
      if (result_valid) begin
        if (result_q.size() == 0) begin
          flag_error({"unexpected result ", fmt_result(result)});
        end else begin
          exp_r = result_q.pop_front();
          if (result.kind !== exp_r.kind || result.target_service !== exp_r.target_service ||
              result.not_started !== exp_r.not_started ||
              result.all_started !== exp_r.all_started || result.last !== exp_r.last)
            flag_error({"expected ", fmt_result(exp_r), " got ", fmt_result(result)});
        end
      end
      if (start && !busy) begin
        if (row_typed) begin
          compute_outcomes(request, 1'b0);
          result_q.push_back(row_expect);
        end else begin
          compute_outcomes(request, 1'b1);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int idle_pct();
    case ((sent / 64) % 4)
      1: return 73;
      3: return 26;
      default: return 0;
    endcase
  endfunction

  task automatic send_request(input dwm_request_t req, input bit typed, input dwm_result_t texp);
    int gap;
    int pct;
    logic [20:0] junk;
    pct = idle_pct();
    gap = 0;
    while (gap < 40 && $urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      junk = 21'($urandom);
      start   <= 1'b0;
      request <= junk;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    request    <= req;
    row_typed  = typed;
    row_expect = texp;
    if (req.opcode == OP_SIGNAL) signaled[req.service] = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic shuffle_services();
    int j;
    int t;
    for (int k = 0; k < NSVC; k++) perm[k] = k;
    for (int k = NSVC - 1; k > 0; k--) begin
      j = $urandom_range(k);
      t = perm[k];
      perm[k] = perm[j];
      perm[j] = t;
    end
  endtask

  initial begin
    int b;
    int r;
    logic [15:0] mask;
    logic [15:0] live;
    dwm_result_t none;

    none = '0;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    errors = 0;
    sent = 0;
    cycle_count = 0;
    signaled = '0;
    row_typed = 1'b0;
    row_expect = '0;
    for (int i = 0; i < NSVC; i++) begin
      dep_rows[i] = 16'hFFFF;
      notify[i] = 1'b0;
    end
    unreleased = NSVC;

    directed_rows.push_back('{mk_req(OP_WAIT, 0, 16'h0020), 1'b1, mk_res(KIND_SLEEP, 0, 16)});
    directed_rows.push_back('{mk_req(OP_SIGNAL, 5, 16'h0000), 1'b1, mk_res(KIND_WAKE, 0, 15)});
    // ready on an empty row: released again
    directed_rows.push_back('{mk_req(OP_WAIT, 0, 16'h0000), 1'b1, mk_res(KIND_READY, 0, 14)});
    directed_rows.push_back('{mk_req(OP_WAIT, 15, 16'hFFFF), 1'b1, mk_res(KIND_SLEEP, 15, 14)});
    // signals that release nothing; mask ignored
    directed_rows.push_back('{mk_req(OP_SIGNAL, 3, 16'hFFFF), 1'b0, none});
    directed_rows.push_back('{mk_req(OP_SIGNAL, 5, 16'h0000), 1'b0, none});
    directed_rows.push_back('{mk_req(OP_WAIT, 0, 16'hFFFF), 1'b1, mk_res(KIND_READY, 0, 13)});
    directed_rows.push_back('{mk_req(OP_WAIT, 8, 16'h0100), 1'b1, mk_res(KIND_SLEEP, 8, 13)});
    directed_rows.push_back('{mk_req(OP_WAIT, 9, 16'h0100), 1'b1, mk_res(KIND_SLEEP, 9, 13)});
    // two wakes from one signal
    directed_rows.push_back('{mk_req(OP_SIGNAL, 8, 16'hA5A5), 1'b0, none});
    directed_rows.push_back('{mk_req(OP_WAIT, 14, 16'h4001), 1'b0, none});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

    while (sent < RANDOM_ITEMS) begin
      live = ~signaled;
      b = 0;
      if (live != 16'h0000) begin
        b = $urandom_range(NSVC - 1);
        while (!live[b]) b = $urandom_range(NSVC - 1);
      end
      shuffle_services();
      for (int k = 0; k < NSVC; k++) begin
        r = $urandom_range(99);
        if (r < 75) begin
          mask = 16'h0001 << b;
          if ($urandom_range(1)) mask |= 16'($urandom) & live;
          send_request(mk_req(OP_WAIT, perm[k], mask), 1'b0, none);
        end else if (r < 85) begin
          send_request(mk_req(OP_WAIT, perm[k], 16'($urandom)), 1'b0, none);
        end
      end
      send_request(mk_req(OP_SIGNAL, b, 16'($urandom)), 1'b0, none);
      if ($urandom_range(99) < 25)
        send_request(mk_req(OP_SIGNAL, $urandom_range(NSVC - 1), 16'($urandom)), 1'b0, none);
    end

    // release every service: count runs down to zero and saturates
    shuffle_services();
    for (int k = 0; k < NSVC; k++)
      send_request(mk_req(OP_WAIT, perm[k], 16'h0000), 1'b0, none);

    start <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (NSVC + 4) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
